/* src/utf8_to_utf32_decoder_assert.svh */
// assertion macros shared by the decoder rtl
`ifndef UTF8_TO_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/u8d_pkg.sv */
// types, constants and decode functions of the utf-8 to utf-32 decoder
package u8d_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned RemW       = $clog2(MaxResults + 1);
  localparam int unsigned SlotW      = $clog2(MaxResults);

  localparam logic [20:0] MaxCode = 21'h10FFFF;

  localparam logic [7:0] MaskAscii = 8'h80;
  localparam logic [7:0] Mask2     = 8'hE0;
  localparam logic [7:0] Lead2     = 8'hC0;
  localparam logic [7:0] Mask3     = 8'hF0;
  localparam logic [7:0] Lead3     = 8'hE0;
  localparam logic [7:0] Mask4     = 8'hF8;
  localparam logic [7:0] Lead4     = 8'hF0;

  // one result entry as queued for the output channel
  typedef struct packed {
    logic [20:0] code_point;
    logic        is_end;
    logic        had_error;
  } res_t;

  // sequence length set by a lead byte, 0 when the byte cannot lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if ((b & MaskAscii) == 8'h00) len = 3'd1;
    else if ((b & Mask2) == Lead2) len = 3'd2;
    else if ((b & Mask3) == Lead3) len = 3'd3;
    else if ((b & Mask4) == Lead4) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  // code point of a multi-byte sequence: held bytes plus the closing byte
  function automatic logic [20:0] assemble(input logic [23:0] held, input logic [7:0] b,
                                           input logic [2:0] len);
    logic [20:0] cp;
    unique case (len)
      3'd2:    cp = {10'd0, held[4:0], b[5:0]};
      3'd3:    cp = {5'd0, held[3:0], held[13:8], b[5:0]};
      default: cp = {held[2:0], held[13:8], held[21:16], b[5:0]};
    endcase
    return cp;
  endfunction

endpackage

/* src/u8d_ifs.sv */
// channel interfaces of the decoder: byte input, result output, config write

interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_end;
  logic        had_error;
  logic        last_of_run;
  modport source (output valid, output code_point, output is_end, output had_error,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_end, input had_error,
                  input last_of_run, output ready);
endinterface

interface u8d_cfg_if;
  logic valid;
  logic ready;
  logic error_policy;
  modport source (output valid, output error_policy, input ready);
  modport sink   (input valid, input error_policy, output ready);
endinterface

/* src/utf8_to_utf32_decoder.sv */
// utf-8 byte stream to utf-32 code point decoder, top level
//
// channels: in_bus takes one utf-8 byte per transaction with end_of_stream
// marking the final byte; out_bus gives code point results and, after the
// final byte, one end result whose had_error reports any error of the
// stream; last_of_run flags the final result caused by one byte. cfg_bus
// writes error_policy (0 skip bad bytes, 1 stop emitting at first error),
// always ready, to be written only while the decoder is idle.
// timing: a byte is decoded in the cycle it is accepted and its results
// sit in a four-entry result queue, so the first result is valid in the
// cycle after acceptance. a byte gives zero to three results; one result
// leaves per cycle while out_bus is ready, so throughput is one byte per
// cycle if no byte yields more than one result; else the queue drains first.
// stall: while out_bus is stalled, the queue holds; a new byte is taken
// once the queue is empty or its last entry leaves in the same cycle.
// reset: rst_n (synchronous, active low) clears the open sequence, the
// error flags, the policy and the result queue; the decoder is ready for
// the first byte in the cycle after reset is released.
`include "utf8_to_utf32_decoder_assert.svh"

module utf8_to_utf32_decoder (
  input  logic      clk,
  input  logic      rst_n,
  u8d_in_if.sink    in_bus,
  u8d_out_if.source out_bus,
  u8d_cfg_if.sink   cfg_bus
);

  // stream state
  logic [23:0] held_r;      // bytes of the open sequence, lead at the bottom
  logic [1:0]  cnt_r;       // bytes held, lead included
  logic [2:0]  len_r;       // length of the open sequence, 0 when none
  logic        err_r;       // sticky error of the current stream
  logic        stop_r;      // stop mode hit an error
  logic        pol_r;       // error policy register

  // result queue, slot 0 faces the output
  u8d_pkg::res_t               queue_r [u8d_pkg::MaxResults];
  logic [u8d_pkg::RemW-1:0]    rem_r;

  logic in_fire;
  logic out_fire;

  // step results of the current byte
  logic [23:0] held_nxt;
  logic [1:0]  cnt_nxt;
  logic [2:0]  len_nxt;
  logic        err_nxt;
  logic        stop_nxt;
  logic [2:0]  lead;
  logic [20:0] asm_cp;
  logic        cut;       // sequence cut short by the end of the stream
  logic [7:0]  h1;
  logic [7:0]  h2;
  logic        had_err;

  u8d_pkg::res_t            step_res;  // code point of the byte step itself
  logic                     step_v;

  u8d_pkg::res_t            cand      [u8d_pkg::MaxResults];
  logic [u8d_pkg::MaxResults-1:0] cand_v;
  u8d_pkg::res_t            packed_q  [u8d_pkg::MaxResults];
  logic [u8d_pkg::RemW-1:0] n_res;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;

  // take a byte when the queue is empty or drains its last entry now
  assign in_bus.ready = (rem_r == '0) ||
                        ((rem_r == u8d_pkg::RemW'(1)) && out_bus.ready);

  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid       = (rem_r != '0);
  assign out_bus.code_point  = queue_r[0].code_point;
  assign out_bus.is_end      = queue_r[0].is_end;
  assign out_bus.had_error   = queue_r[0].had_error;
  assign out_bus.last_of_run = (rem_r == u8d_pkg::RemW'(1));

  assign lead   = u8d_pkg::lead_len(in_bus.data_byte);
  assign asm_cp = u8d_pkg::assemble(held_r, in_bus.data_byte, len_r);

  // byte step: take an ascii or stray byte, or open, extend or close a sequence
  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    err_nxt  = err_r;
    stop_nxt = stop_r;
    step_res = '0;
    step_v   = 1'b0;
    if (!stop_r) begin
      if (len_r == 3'd0) begin
        if (lead == 3'd0) begin
          // stray byte that cannot lead
          err_nxt  = 1'b1;
          stop_nxt = pol_r;
        end else if (lead == 3'd1) begin
          step_v = 1'b1;
          step_res.code_point = {13'd0, in_bus.data_byte};
        end else begin
          held_nxt = {16'd0, in_bus.data_byte};
          cnt_nxt  = 2'd1;
          len_nxt  = lead;
        end
      end else if (({1'b0, cnt_r} + 3'd1) >= len_r) begin
        // closing byte
        if (asm_cp > u8d_pkg::MaxCode) begin
          err_nxt  = 1'b1;
          stop_nxt = pol_r;
        end else begin
          step_v = 1'b1;
          step_res.code_point = asm_cp;
        end
        held_nxt = '0;
        cnt_nxt  = '0;
        len_nxt  = '0;
      end else begin
        held_nxt[8*cnt_r +: 8] = in_bus.data_byte;
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  // end of stream: a cut sequence drops its lead, the rest is decoded again
  assign cut     = in_bus.end_of_stream && !stop_nxt && (len_nxt != 3'd0);
  assign h1      = held_nxt[15:8];
  assign h2      = held_nxt[23:16];
  assign had_err = err_nxt | cut;

  always_comb begin
    cand[0]   = step_res;
    cand_v[0] = step_v;
    cand[1]   = '0;
    cand[2]   = '0;
    cand_v[1] = 1'b0;
    cand_v[2] = 1'b0;
    // only skip mode goes on past the dropped lead
    if (cut && !pol_r) begin
      if (cnt_nxt == 2'd2) begin
        if (!h1[7]) begin
          cand_v[1] = 1'b1;
          cand[1].code_point = {13'd0, h1};
        end
      end else if (cnt_nxt == 2'd3) begin
        if (!h1[7]) begin
          cand_v[1] = 1'b1;
          cand[1].code_point = {13'd0, h1};
          if (!h2[7]) begin
            cand_v[2] = 1'b1;
            cand[2].code_point = {13'd0, h2};
          end
        end else if (u8d_pkg::lead_len(h1) == 3'd2) begin
          cand_v[1] = 1'b1;
          cand[1].code_point = {10'd0, h1[4:0], h2[5:0]};
        end else if (!h2[7]) begin
          cand_v[1] = 1'b1;
          cand[1].code_point = {13'd0, h2};
        end
      end
    end
    cand_v[3]          = in_bus.end_of_stream;
    cand[3].code_point = '0;
    cand[3].is_end     = 1'b1;
    cand[3].had_error  = had_err;
  end

  // pack the present results in order
  always_comb begin
    n_res = '0;
    for (int k = 0; k < u8d_pkg::MaxResults; k++) begin
      packed_q[k] = '0;
    end
    for (int k = 0; k < u8d_pkg::MaxResults; k++) begin
      if (cand_v[k]) begin
        packed_q[n_res[u8d_pkg::SlotW-1:0]] = cand[k];
        n_res = n_res + u8d_pkg::RemW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= '0;
      len_r  <= '0;
      err_r  <= 1'b0;
      stop_r <= 1'b0;
      pol_r  <= 1'b0;
      rem_r  <= '0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        pol_r <= cfg_bus.error_policy;
      end
      if (in_fire) begin
        if (in_bus.end_of_stream) begin
          // new stream starts clean
          held_r <= '0;
          cnt_r  <= '0;
          len_r  <= '0;
          err_r  <= 1'b0;
          stop_r <= 1'b0;
        end else begin
          held_r <= held_nxt;
          cnt_r  <= cnt_nxt;
          len_r  <= len_nxt;
          err_r  <= err_nxt;
          stop_r <= stop_nxt;
        end
        rem_r <= n_res;
      end else if (out_fire) begin
        rem_r <= rem_r - u8d_pkg::RemW'(1);
      end
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < u8d_pkg::MaxResults; k++) begin
        queue_r[k] <= packed_q[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < u8d_pkg::MaxResults - 1; k++) begin
        queue_r[k] <= queue_r[k + 1];
      end
    end
  end

  `U8D_ASSERT_NOW(a_open_seq_count, len_r != 3'd0,
                  (cnt_r != 2'd0) && ({1'b0, cnt_r} < len_r), "held count out of range")
  `U8D_ASSERT_NOW(a_stop_has_error, stop_r, err_r, "stopped without an error")
  `U8D_ASSERT_NEXT(a_eos_clears, in_fire && in_bus.end_of_stream,
                   (len_r == 3'd0) && !err_r && !stop_r && (rem_r != '0),
                   "stream state not cleared after end byte")
  `U8D_ASSERT_NOW(a_end_is_last, out_bus.valid && out_bus.is_end,
                  rem_r == u8d_pkg::RemW'(1), "end result not last in queue")
  `U8D_ASSERT_NOW(a_accept_drains, in_fire,
                  (rem_r == '0) || ((rem_r == u8d_pkg::RemW'(1)) && out_fire),
                  "byte taken over pending results")

endmodule

/* test/utf8_to_utf32_decoder_test.sv */
// self-checking testbench of the utf-8 to utf-32 stream decoder
`timescale 1ns / 100ps

module utf8_to_utf32_decoder_test;

  // error_policy values
  localparam logic PolicySkip = 1'b0;
  localparam logic PolicyStop = 1'b1;

  localparam int RandomBytes  = 470;     // least number of bytes sent in the random part
  localparam int SettleCycles = 4;       // a byte is decoded in its accept cycle, results follow
  localparam int CycleLimit   = 600000;  // far above the slowest legal run

  // one result transaction as seen on out_bus
  typedef struct packed {
    logic [20:0] code_point;
    logic        is_end;
    logic        had_error;
    logic        last_of_run;
  } decoded_t;

  logic clk = 1'b0;
  logic rst_n;

  u8d_in_if  in_ch();
  u8d_out_if out_ch();
  u8d_cfg_if cfg_ch();

  utf8_to_utf32_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  // decoder state as the testbench predicts it
  logic        policy;
  logic [23:0] open_bytes;    // bytes of the open sequence, lead in the low byte
  logic [1:0]  open_count;    // bytes held, lead included
  logic [2:0]  open_len;      // length of the open sequence, 0 if none
  logic        stream_error;  // sticky error flag of the current stream
  logic        halted;        // stop mode hit an error, data ignored until the end byte

  decoded_t due_results[$];   // results still to come, oldest first
  decoded_t byte_results[$];  // results of the byte being decoded

  bit gaps_on;
  bit stalls_on;
  int cycle_count;
  int fail_count;
  int bytes_decoded;
  int code_points_seen;
  int ends_seen;
  int error_ends_seen;

  always #4 clk = ~clk;

  // run limit, counted from time zero
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // sequence length announced by a lead byte, 0 for bytes that cannot lead
  function automatic logic [2:0] seq_len_of(logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  // value of a sequence of len bytes, byte k at bits 8k+7..8k; the top bits
  // of continuation bytes are not looked at
  function automatic logic [20:0] code_point_of(logic [31:0] s, logic [2:0] len);
    case (len)
      3'd2:    return {10'd0, s[4:0], s[13:8]};
      3'd3:    return {5'd0, s[3:0], s[13:8], s[21:16]};
      3'd4:    return {s[2:0], s[13:8], s[21:16], s[29:24]};
      default: return {14'd0, s[6:0]};
    endcase
  endfunction

  function automatic void note_error();
    stream_error = 1'b1;
    if (policy == PolicyStop) halted = 1'b1;
  endfunction

  function automatic void emit(logic [20:0] cp, logic is_end, logic err);
    decoded_t res;
    res.code_point  = cp;
    res.is_end      = is_end;
    res.had_error   = err;
    res.last_of_run = 1'b0;
    byte_results.insert(byte_results.size(), res);
  endfunction

  // a complete sequence gives its code point unless it is above the unicode range
  function automatic void close_sequence(logic [31:0] s, logic [2:0] len);
    logic [20:0] cp;
    cp = code_point_of(s, len);
    if (cp > u8d_pkg::MaxCode) note_error();
    else emit(cp, 1'b0, 1'b0);
  endfunction

  // step the predicted decoder by one accepted byte and queue what it gives
  function automatic void decode_byte(logic [7:0] b, logic eos);
    logic [31:0] s;
    logic [2:0]  len;
    int          i;
    int          held;
    byte_results.delete();
    if (!halted) begin
      if (open_len == 3'd0) begin
        len = seq_len_of(b);
        if (len == 3'd0) begin
          note_error();  // stray continuation or 11111xxx: one byte dropped
        end else if (len == 3'd1) begin
          emit({13'd0, b}, 1'b0, 1'b0);
        end else begin
          open_bytes = {16'd0, b};
          open_count = 2'd1;
          open_len   = len;
        end
      end else if (open_count + 1 >= open_len) begin
        s = {8'd0, open_bytes};
        s[8*open_count +: 8] = b;
        close_sequence(s, open_len);
        open_bytes = '0;
        open_count = '0;
        open_len   = '0;
      end else begin
        open_bytes[8*open_count +: 8] = b;
        open_count = open_count + 2'd1;
      end
    end
    if (eos) begin
      // sequence cut short: the lead is an error, the bytes after it are
      // decoded again as a stream ending here, each failure dropping one byte
      if (!halted && open_len != 3'd0) begin
        held = int'(open_count);
        s    = {8'd0, open_bytes};
        note_error();
        i = 1;
        while (i < held && !halted) begin
          len = seq_len_of(s[8*i +: 8]);
          if (len != 3'd0 && i + len <= held) begin
            close_sequence(s >> (8 * i), len);
            i += len;
          end else begin
            note_error();
            i++;
          end
        end
      end
      emit(21'd0, 1'b1, stream_error);
      open_bytes   = '0;
      open_count   = '0;
      open_len     = '0;
      stream_error = 1'b0;
      halted       = 1'b0;
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
    foreach (byte_results[k]) due_results.insert(due_results.size(), byte_results[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [20:0] want, logic [20:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // every result transaction is held against the oldest prediction
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with none predicted: code_point %0h is_end %b",
               out_ch.code_point, out_ch.is_end);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("code_point", want.code_point, out_ch.code_point);
        check_field("is_end", 21'(want.is_end), 21'(out_ch.is_end));
        check_field("had_error", 21'(want.had_error), 21'(out_ch.had_error));
        check_field("last_of_run", 21'(want.last_of_run), 21'(out_ch.last_of_run));
        if (want.is_end) begin
          ends_seen++;
          if (want.had_error) error_ends_seen++;
        end else begin
          code_points_seen++;
        end
      end
    end
  end

  // result side backpressure: random stalls while stalls_on, none otherwise
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one byte transaction; valid stays high afterwards so that back-to-back
  // bytes follow without a gap, callers that pause lower it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    bytes_decoded++;
    decode_byte(b, eos);
  endtask

  // hold off the sender until every predicted result is out and the
  // decoder has had time to finish bytes that give no result
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // register write, only ever while the decoder is idle
  task automatic write_policy(input logic p);
    wait_idle();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.error_policy <= p;
    do @(posedge clk); while (!cfg_ch.ready);
    policy = p;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);  // ascii on the end byte: code point then end result
  endtask

  task automatic test_multi_byte();
    // largest two and three byte values
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // top of the unicode range
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // overlong form whose continuation byte is itself a lead byte
    send_byte(8'hC0, 1'b0);
    send_byte(8'hC0, 1'b1);
  endtask

  task automatic test_bad_bytes();
    send_byte(8'h80, 1'b0);  // stray continuation
    send_byte(8'hFF, 1'b0);  // 11111xxx can never lead
    // one past the unicode range, the whole sequence is dropped
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b1);  // end result reports the errors
  endtask

  task automatic test_cut_short();
    // four byte lead cut off after two more bytes: lead dropped, the two
    // held bytes decode again as a complete two byte sequence
    send_byte(8'hF0, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
  endtask

  task automatic test_stop_policy();
    write_policy(PolicyStop);
    send_byte(8'h80, 1'b0);  // error stops the stream
    send_byte(8'h41, 1'b0);  // ignored
    write_policy(PolicySkip);
    send_byte(8'h42, 1'b0);  // still ignored, going back to skip does not restart
    send_byte(8'h43, 1'b1);  // end result is given regardless
    // cut-short sequence in stop mode gives nothing but the end result
    write_policy(PolicyStop);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  // one stream of mostly well-formed characters with random payloads, a
  // few noise bytes and now and then a tail cut off
  task automatic send_stream();
    logic [7:0]  seq[$];
    logic [31:0] r;
    int          chars;
    int          len;
    int          mid;
    chars = $urandom_range(1, 10);
    for (int c = 0; c < chars; c++) begin
      r = $urandom;
      if (r[31:28] == 4'd0) begin
        seq.insert(seq.size(), r[7:0]);  // noise, any byte at all
      end else begin
        len = $urandom_range(1, 4);
        case (len)
          1: seq.insert(seq.size(), {1'b0, r[6:0]});
          2: seq.insert(seq.size(), {3'b110, r[4:0]});
          3: seq.insert(seq.size(), {4'b1110, r[3:0]});
          // keep most four byte values inside the unicode range
          default: seq.insert(seq.size(),
                              {5'b11110, (r[10:8] == 3'd7) ? r[2:0] : {1'b0, r[1:0]}});
        endcase
        for (int k = 1; k < len; k++) begin
          r = $urandom;
          seq.insert(seq.size(), (r[31:29] == 3'd0) ? r[7:0] : {2'b10, r[5:0]});
        end
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, 2);
      while (len > 0 && seq.size() > 1) begin
        void'(seq.pop_back());
        len--;
      end
    end
    mid = $urandom_range(0, seq.size() - 1);
    foreach (seq[i]) begin
      // now and then drain in mid-stream, sometimes switching the policy there
      if (i == mid && i > 0 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) write_policy($urandom_range(0, 1) ? PolicyStop : PolicySkip);
        else wait_idle();
      end
      send_byte(seq[i], i == seq.size() - 1);
    end
  endtask

  task automatic test_random_streams();
    int start;
    int streams;
    start   = bytes_decoded;
    streams = 0;
    while (bytes_decoded - start < RandomBytes) begin
      // new phase: idling pattern and policy picked again
      if (streams % 6 == 0) begin
        gaps_on   = $urandom_range(0, 2) != 0;
        stalls_on = $urandom_range(0, 2) != 0;
        write_policy(($urandom_range(0, 3) == 0) ? PolicyStop : PolicySkip);
      end
      send_stream();
      streams++;
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'h00;
    in_ch.end_of_stream <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.error_policy <= PolicySkip;
    policy       = PolicySkip;
    open_bytes   = '0;
    open_count   = '0;
    open_len     = '0;
    stream_error = 1'b0;
    halted       = 1'b0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_single_bytes();
    test_multi_byte();
    test_bad_bytes();
    test_cut_short();
    test_stop_policy();
    test_random_streams();

    wait_idle();
    $display("sent %0d bytes over %0d streams under both error policies",
             bytes_decoded, ends_seen);
    $display("checked %0d code points and %0d end results, %0d of them reporting errors",
             code_points_seen, ends_seen, error_ends_seen);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
